/* rtl/core/slcg_pkg.sv */
// Package with shared constants, types and the sine polynomial coefficients.
package slcg_pkg;
    localparam int MAX_HALF_LENGTH = 31;
    localparam int COEF_FRAC_BITS  = 16;
    localparam int PHASE_BITS      = 24;
    localparam logic [23:0] RESET_SAMPLE_RATE = 24'd48000;
    localparam logic [4:0]  RESET_HALF_LENGTH = 5'd15;
    localparam logic [0:0]  CFG_SAMPLE_RATE = 1'b0;
    localparam logic [0:0]  CFG_HALF_LENGTH = 1'b1;
    localparam logic [30:0] SIN_C1 = 31'd1686629713;
    localparam logic [30:0] SIN_C3 = 31'd693598668;
    localparam logic [30:0] SIN_C5 = 31'd85569306;
    localparam logic [30:0] SIN_C7 = 31'd5026995;
    localparam logic [30:0] SIN_C9 = 31'd172272;
    localparam logic [28:0] INV_PI_Q30 = 29'd341782638;
    localparam logic signed [17:0] COEF_MAX = 18'sd131071;
    localparam logic signed [17:0] COEF_MIN = -18'sd131072;
    typedef logic signed [31:0] t_half_coef;
endpackage

/* rtl/core/slcg_ram.sv */
// Generic single-port RAM with registered read.
module slcg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* rtl/core/slcg_divider.sv */
// Restoring bit-serial unsigned divider, one quotient bit per cycle.
module slcg_divider #(
    parameter int NW = 64,
    parameter int DW = 48
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_go,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);
    logic [NW-1:0] r_q;
    logic [DW:0]   r_rem;
    logic [DW-1:0] r_den;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [DW:0]   n_rem;
    logic [DW+1:0] n_diff;
    always_comb begin
        n_rem  = {r_rem[DW-1:0], r_q[NW-1]};
        n_diff = {1'b0, n_rem} - {2'b00, r_den};
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_go) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(NW);
                r_q    <= i_num;
                r_den  <= i_den;
                r_rem  <= '0;
            end else if (r_busy) begin
                if (!n_diff[DW+1]) begin
                    r_rem <= n_diff[DW:0];
                    r_q   <= {r_q[NW-2:0], 1'b1};
                end else begin
                    r_rem <= n_rem;
                    r_q   <= {r_q[NW-2:0], 1'b0};
                end
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule

/* rtl/core/sinc_lowpass_coefficient_generator_core.sv */
// Top level of the sinc low-pass coefficient generator.
// A request computes the centre tap and the outer taps one after another with one shared
// multiplier and one bit-serial divider, stores them in a RAM of MAX_HALF_LENGTH + 1
// entries, then reads each stored tap back and divides it by the tap sum; when that sum
// is zero, every beat gives a zero coefficient and no normalising division is done. Each
// result beat is shown for one cycle and cannot be stalled. Busy falls in the cycle that
// shows the last beat, so the next request can be accepted at its end.
module sinc_lowpass_coefficient_generator_core #(
    parameter int MAX_HALF_LENGTH = slcg_pkg::MAX_HALF_LENGTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [23:0] i_cfg_data,
    input  logic [23:0] i_cutoff_hz,
    output logic        o_valid,
    output logic [5:0]  o_tap_index,
    output logic signed [17:0] o_coefficient,
    output logic        o_sum_zero,
    output logic        o_last
);
    import slcg_pkg::*;
    localparam int AW = (MAX_HALF_LENGTH < 2) ? 1 : $clog2(MAX_HALF_LENGTH + 1);
    localparam logic [4:0] MAXM = (MAX_HALF_LENGTH > 31) ? 5'd31 : 5'(MAX_HALF_LENGTH);

    localparam logic [3:0] S_IDLE = 4'd0, S_CDIV = 4'd1, S_SDIV = 4'd2, S_PH = 4'd3,
        S_SIN = 4'd4, S_TDIV = 4'd5, S_TW = 4'd6, S_ZRD = 4'd7, S_ZW = 4'd8,
        S_NDIV = 4'd9, S_NOUT = 4'd10, S_CW = 4'd11;

    logic [3:0]  r_st;
    logic [23:0] r_fs;
    logic [4:0]  r_hl;
    logic [24:0] r_u;
    logic [24:0] r_fsx;
    logic [4:0]  r_m;
    logic [23:0] r_step;
    logic [4:0]  r_k;
    logic [5:0]  r_i;
    logic [3:0]  r_ps;
    logic [31:0] r_t;
    logic [31:0] r_t2;
    logic [31:0] r_p;
    logic        r_neg;
    logic signed [39:0] r_sum;
    logic        r_zero;

    logic        div_go, div_done;
    logic [63:0] div_num, div_q;
    logic [47:0] div_den;
    slcg_divider #(.NW(64), .DW(48)) u_div (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_go(div_go), .i_num(div_num),
        .i_den(div_den), .o_done(div_done), .o_quot(div_q));

    logic        ram_we;
    logic [AW-1:0] ram_addr;
    logic [31:0] ram_wd, ram_rd;
    slcg_ram #(.WIDTH(32), .DEPTH(MAX_HALF_LENGTH + 1)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr), .i_wdata(ram_wd),
        .o_rdata(ram_rd));

    logic [31:0] mul_a, mul_b;
    logic [63:0] mul_p;
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

    logic [5:0]  total_m1;
    logic [4:0]  i_k;
    logic [31:0] phase_x;
    logic signed [31:0] rd_s;
    logic [31:0] rd_mag;
    logic [39:0] sum_mag;
    logic [17:0] qsat;
    logic signed [17:0] coef;
    assign total_m1 = {r_m, 1'b0};
    assign i_k = (r_i < {1'b0, r_m}) ? 5'(r_m - r_i[4:0]) : 5'(r_i[4:0] - r_m);
    assign rd_s = ram_rd;
    assign rd_mag = rd_s[31] ? 32'(-rd_s) : ram_rd;
    assign sum_mag = r_sum[39] ? 40'(-r_sum) : r_sum;
    assign phase_x = {r_t[23:0], 8'd0};
    assign qsat = (div_q[63:18] != 0) ? 18'h3ffff : div_q[17:0];

    always_comb begin
        mul_a = r_t2;
        mul_b = r_p;
        case (r_ps)
            4'd0: begin mul_a = r_t; mul_b = r_t; end
            4'd1: begin mul_a = r_t2; mul_b = 32'(SIN_C9); end
            4'd6: begin mul_a = r_t; mul_b = r_p; end
            4'd7: begin mul_a = r_p; mul_b = 32'(INV_PI_Q30); end
            4'd8: begin mul_a = 32'(r_step); mul_b = 32'(r_k); end
            default: ;
        endcase
    end

    always_comb begin
        if (r_neg) begin
            coef = (qsat > 18'd131072) ? COEF_MIN : 18'(-$signed({1'b0, qsat}));
        end else begin
            coef = (qsat > 18'd131071) ? COEF_MAX : $signed(qsat);
        end
    end

    always_comb begin
        ram_we = 1'b0;
        ram_addr = AW'(r_k);
        ram_wd = div_q[31:0];
        div_go = 1'b0;
        div_num = '0;
        div_den = 48'(r_fsx);
        case (r_st)
            S_CDIV: begin
                div_go = (r_ps == 4'd15);
                div_num = (64'(r_u) << 30) + 64'(r_fsx[24:1]);
            end
            S_SDIV: begin
                div_go = (r_ps == 4'd15);
                div_num = 64'(r_u) << (PHASE_BITS - 1);
            end
            S_TDIV: begin
                div_go = (r_ps == 4'd15);
                div_num = {r_t, r_t2} + (64'(r_k) << 29);
                div_den = 48'(r_k) << 30;
            end
            S_CW: begin
                ram_we = 1'b1;
                ram_addr = '0;
            end
            S_TW: begin
                ram_we = 1'b1;
                ram_wd = r_neg ? 32'(-div_q[31:0]) : div_q[31:0];
            end
            S_NDIV: begin
                ram_addr = AW'(i_k);
                div_go = (r_ps == 4'd15) && !r_zero;
                div_num = (64'(rd_mag) << COEF_FRAC_BITS) + 64'(sum_mag[39:1]);
                div_den = 48'(sum_mag);
            end
            S_ZRD, S_ZW, S_NOUT: ram_addr = AW'(i_k);
            default: ;
        endcase
    end

    assign busy = (r_st != S_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_fs <= RESET_SAMPLE_RATE;
            r_hl <= RESET_HALF_LENGTH;
            r_sum <= '0;
            o_valid <= 1'b0;
            r_ps <= '0;
        end else begin
            o_valid <= 1'b0;
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_SAMPLE_RATE: r_fs <= i_cfg_data;
                    CFG_HALF_LENGTH: r_hl <= i_cfg_data[4:0];
                    default: ;
                endcase
            end
            case (r_st)
                S_IDLE: if (start) begin
                    r_fsx <= (r_fs == 0) ? 25'd1 : {1'b0, r_fs};
                    r_u <= ({i_cutoff_hz, 1'b0} > ((r_fs == 0) ? 25'd1 : {1'b0, r_fs}))
                         ? ((r_fs == 0) ? 25'd1 : {1'b0, r_fs}) : {i_cutoff_hz, 1'b0};
                    r_m <= (r_hl > MAXM) ? MAXM : r_hl;
                    r_ps <= 4'd15;
                    r_st <= S_CDIV;
                end
                S_CDIV: begin
                    if (r_ps == 4'd15) r_ps <= 4'd14;
                    if (div_done) begin
                        r_sum <= 40'(div_q[31:0]);
                        r_st <= S_CW;
                    end
                end
                S_CW: begin
                    r_ps <= 4'd15;
                    r_st <= S_SDIV;
                end
                S_SDIV: begin
                    if (r_ps == 4'd15) r_ps <= 4'd14;
                    if (div_done) begin
                        r_step <= div_q[23:0];
                        r_k <= 5'd1;
                        r_ps <= 4'd8;
                        r_st <= (r_m == 0) ? S_ZRD : S_PH;
                        r_i <= '0;
                    end
                end
                S_PH: begin
                    r_t <= {8'd0, mul_p[23:0]};
                    r_ps <= 4'd9;
                    r_st <= S_SIN;
                end
                S_SIN: begin
                    case (r_ps)
                        4'd9: begin
                            r_neg <= phase_x[31];
                            r_t <= phase_x[30] ? 32'((33'd1 << 30) - phase_x[29:0])
                                               : {2'd0, phase_x[29:0]};
                            r_ps <= 4'd0;
                        end
                        4'd0: begin r_t2 <= mul_p[61:30]; r_ps <= 4'd1; end
                        4'd1: begin
                            r_p <= 32'(SIN_C7) - mul_p[61:30]; r_ps <= 4'd2;
                        end
                        4'd2: begin r_p <= 32'(SIN_C5) - mul_p[61:30]; r_ps <= 4'd3; end
                        4'd3: begin r_p <= 32'(SIN_C3) - mul_p[61:30]; r_ps <= 4'd4; end
                        4'd4: begin r_p <= 32'(SIN_C1) - mul_p[61:30]; r_ps <= 4'd6; end
                        4'd6: begin
                            r_p <= (mul_p[63:30] > 34'(1 << 30)) ? 32'(1 << 30)
                                                                  : mul_p[61:30];
                            r_ps <= 4'd7;
                        end
                        4'd7: begin
                            r_t <= 32'(mul_p[63:32]);
                            r_t2 <= mul_p[31:0];
                            r_ps <= 4'd15;
                            r_st <= S_TDIV;
                        end
                        default: r_ps <= 4'd0;
                    endcase
                end
                S_TDIV: begin
                    if (r_ps == 4'd15) r_ps <= 4'd14;
                    if (div_done) r_st <= S_TW;
                end
                S_TW: begin
                    r_sum <= r_sum + (r_neg ? -40'(div_q[31:0]) : 40'(div_q[31:0])) * 2;
                    r_ps <= 4'd8;
                    if (r_k == r_m) begin
                        r_st <= S_ZRD;
                        r_i <= '0;
                    end else begin
                        r_k <= r_k + 1'b1;
                        r_st <= S_PH;
                    end
                end
                S_ZRD: begin
                    r_zero <= (r_sum == 0);
                    r_st <= S_ZW;
                end
                S_ZW: begin
                    r_neg <= rd_s[31] ^ r_sum[39];
                    r_ps <= 4'd15;
                    r_st <= S_NDIV;
                end
                S_NDIV: begin
                    if (r_ps == 4'd15) r_ps <= 4'd14;
                    if (r_zero || div_done) r_st <= S_NOUT;
                end
                S_NOUT: begin
                    o_valid <= 1'b1;
                    o_tap_index <= r_i;
                    o_coefficient <= r_zero ? 18'sd0 : coef;
                    o_sum_zero <= r_zero;
                    o_last <= (r_i == total_m1);
                    if (r_i == total_m1) begin
                        r_st <= S_IDLE;
                    end else begin
                        r_i <= r_i + 1'b1;
                        r_st <= S_ZRD;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
